// ----- hdl/mis_pkg.sv -----
// Shared types and constants of the merge-insertion sorter.
// Used by mis_cell and merge_insertion_sorter; no dependencies.
package mis_pkg;

  localparam int STATE_W = 2;

  localparam logic [STATE_W-1:0] ST_COLLECT = 2'd0;
  localparam logic [STATE_W-1:0] ST_DRAIN   = 2'd1;
  localparam logic [STATE_W-1:0] ST_EMIT    = 2'd2;

  typedef struct packed {
    logic shift_en;
  } cell_ctl_t;

endpackage

// ----- hdl/mis_cell.sv -----
// Systolic insertion cell: holds one value, keeps the smaller of held and
// incoming value, passes the larger on; shifts on shift_en. Uses mis_pkg.
module mis_cell #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mis_pkg::cell_ctl_t            ctl,
  input  logic                          cin_valid,
  input  logic signed [VALUE_WIDTH-1:0] cin_value,
  output logic                          cout_valid,
  output logic signed [VALUE_WIDTH-1:0] cout_value,
  input  logic                          sin_full,
  input  logic signed [VALUE_WIDTH-1:0] sin_value,
  output logic                          full,
  output logic signed [VALUE_WIDTH-1:0] value
);
  import mis_pkg::*;

  logic                          full_r, full_nxt;
  logic signed [VALUE_WIDTH-1:0] value_r, value_nxt;
  logic                          cout_valid_r, cout_valid_nxt;
  logic signed [VALUE_WIDTH-1:0] cout_value_r, cout_value_nxt;

  always_comb begin
    full_nxt       = full_r;
    value_nxt      = value_r;
    cout_valid_nxt = 1'b0;
    cout_value_nxt = cout_value_r;
    if (ctl.shift_en) begin
      full_nxt  = sin_full;
      value_nxt = sin_value;
    end else if (cin_valid) begin
      priority if (!full_r) begin
        full_nxt  = 1'b1;
        value_nxt = cin_value;
      end else if (cin_value < value_r) begin
        value_nxt      = cin_value;
        cout_valid_nxt = 1'b1;
        cout_value_nxt = value_r;
      end else begin
        cout_valid_nxt = 1'b1;
        cout_value_nxt = cin_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r       <= 1'b0;
      cout_valid_r <= 1'b0;
    end else begin
      full_r       <= full_nxt;
      cout_valid_r <= cout_valid_nxt;
    end
    value_r      <= value_nxt;
    cout_value_r <= cout_value_nxt;
  end

  assign full       = full_r;
  assign value      = value_r;
  assign cout_valid = cout_valid_r;
  assign cout_value = cout_value_r;

endmodule

// ----- hdl/merge_insertion_sorter.sv -----
// Merge-insertion sorter: collects a run of signed values in a systolic
// insertion chain and streams them out in non-decreasing order.
// Depends on mis_pkg and mis_cell.
//
// Input channel (in_*): one value per transaction in in_tdata, in_tlast on
// the final value of a run. One value is taken per cycle while collecting;
// each value ripples down the chain of MAX_ITEMS cells one cell per cycle.
// Values beyond MAX_ITEMS are dropped and flag overflow for the run.
// After the last value is taken, in_tready stays low while the chain
// settles in the drain state, then the held values leave on the output
// channel (out_*), smallest first, one per cycle when out_tready is high.
// out_tlast marks the final value, out_tuser carries the overflow flag.
// A new run is accepted once the last value of the run has been loaded
// into the output register. A stalled receiver holds the output register
// and the chain. Synchronous reset empties the chain and clears the count
// and overflow flag.
module merge_insertion_sorter #(
  parameter int MAX_ITEMS   = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0]     in_tdata,  // value
  input  logic                                 in_tlast,  // last_in
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [((VALUE_WIDTH+7)/8)*8-1:0]     out_tdata, // sorted_value
  output logic                                 out_tlast, // last_out
  output logic                                 out_tuser  // overflow
);
  import mis_pkg::*;

  localparam int DATA_W = ((VALUE_WIDTH + 7) / 8) * 8;
  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int DRN_W  = $clog2(MAX_ITEMS + 2);

  logic [STATE_W-1:0]            state_r, state_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic [DRN_W-1:0]              drain_r, drain_nxt;
  logic                          ovf_r, ovf_nxt;
  logic                          ins_valid_r, ins_valid_nxt;
  logic signed [VALUE_WIDTH-1:0] ins_value_r;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [VALUE_WIDTH-1:0] out_value_r, out_value_nxt;
  logic                          out_last_r, out_last_nxt;
  logic                          out_ovf_r, out_ovf_nxt;

  logic                          accept_in;
  logic                          room;
  cell_ctl_t                     ctl;

  logic                          carry_valid [MAX_ITEMS+1];
  logic signed [VALUE_WIDTH-1:0] carry_value [MAX_ITEMS+1];
  logic                          cell_full   [MAX_ITEMS+1];
  logic signed [VALUE_WIDTH-1:0] cell_value  [MAX_ITEMS+1];
  logic [MAX_ITEMS-1:0]          full_vec;

  assign in_tready = (state_r == ST_COLLECT);
  assign accept_in = in_tvalid && in_tready;
  assign room      = (count_r < CNT_W'(MAX_ITEMS));

  assign carry_valid[0] = ins_valid_r;
  assign carry_value[0] = ins_value_r;
  assign cell_full[MAX_ITEMS]  = 1'b0;
  assign cell_value[MAX_ITEMS] = '0;

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    mis_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .cin_valid (carry_valid[i]),
      .cin_value (carry_value[i]),
      .cout_valid(carry_valid[i+1]),
      .cout_value(carry_value[i+1]),
      .sin_full  (cell_full[i+1]),
      .sin_value (cell_value[i+1]),
      .full      (cell_full[i]),
      .value     (cell_value[i])
    );
    assign full_vec[i] = cell_full[i];
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    drain_nxt     = drain_r;
    ovf_nxt       = ovf_r;
    ins_valid_nxt = accept_in && room;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    ctl.shift_en  = 1'b0;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_COLLECT: begin
        if (accept_in) begin
          if (room) begin
            count_nxt = count_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_tlast) begin
            state_nxt = ST_DRAIN;
            drain_nxt = DRN_W'(MAX_ITEMS);
          end
        end
      end
      ST_DRAIN: begin
        if (drain_r == '0) begin
          state_nxt = ST_EMIT;
        end else begin
          drain_nxt = drain_r - DRN_W'(1);
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          ctl.shift_en  = 1'b1;
          out_valid_nxt = 1'b1;
          out_value_nxt = cell_value[0];
          out_last_nxt  = (count_r == CNT_W'(1));
          out_ovf_nxt   = ovf_r;
          count_nxt     = count_r - CNT_W'(1);
          if (count_r == CNT_W'(1)) begin
            state_nxt = ST_COLLECT;
            ovf_nxt   = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_COLLECT;
      count_r     <= '0;
      drain_r     <= '0;
      ovf_r       <= 1'b0;
      ins_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      drain_r     <= drain_nxt;
      ovf_r       <= ovf_nxt;
      ins_valid_r <= ins_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ins_value_r <= in_tdata[VALUE_WIDTH-1:0];
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = DATA_W'(unsigned'(out_value_r));
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

  a_no_chain_spill: assert property (@(posedge clk) disable iff (!rst_n)
    !carry_valid[MAX_ITEMS])
    else $error("value carried past the last cell");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ITEMS))
    else $error("item count beyond capacity");

  a_emit_head_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> full_vec[0])
    else $error("emitting from an empty chain head");

  a_full_le_count: assert property (@(posedge clk) disable iff (!rst_n)
    ($countones(full_vec) <= int'(count_r)))
    else $error("more cells occupied than values held");

  a_settled_before_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> ($countones(full_vec) == int'(count_r)))
    else $error("chain not settled at output");

endmodule

// ----- tb/merge_insertion_sorter_checker.sv -----
// Checker for merge_insertion_sorter: watches both stream channels, predicts
// the sorted output of every run and compares it with each output transaction.
// Standalone; hands a failure count and an outstanding-result count upward.
module merge_insertion_sorter_checker #(
  parameter int MAX_ITEMS   = 64,
  parameter int VALUE_WIDTH = 32,
  parameter int DATA_W      = ((VALUE_WIDTH+7)/8)*8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,
  input  logic              in_tlast,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [DATA_W-1:0] out_tdata,
  input  logic              out_tlast,
  input  logic              out_tuser,
  output int unsigned       failures,
  output int unsigned       pending
);

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic                   last;
    logic                   overflow;
  } sorted_item_t;

  logic signed [VALUE_WIDTH-1:0] run_held[$];
  logic                          run_overflow = 1'b0;
  sorted_item_t                  sorted_expected[$];
  int unsigned                   fail_count = 0;

  always @(posedge clk) begin : watch
    logic signed [VALUE_WIDTH-1:0] v;
    int unsigned                   pos;
    sorted_item_t                  got;
    sorted_item_t                  want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.value    = out_tdata[VALUE_WIDTH-1:0];
        got.last     = out_tlast;
        got.overflow = out_tuser;
        if (sorted_expected.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result: value %0d last %0b overflow %0b",
                     $signed(got.value), got.last, got.overflow);
          fail_count++;
        end else begin
          want = sorted_expected.pop_front();
          if (got.value !== want.value || got.last !== want.last ||
              got.overflow !== want.overflow) begin
            if (fail_count < 10)
              $display("mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                       $signed(want.value), want.last, want.overflow,
                       $signed(got.value), got.last, got.overflow);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        v = in_tdata[VALUE_WIDTH-1:0];
        if (run_held.size() < MAX_ITEMS) begin
          pos = 0;
          while (pos < run_held.size() && run_held[pos] <= v)
            pos++;
          run_held.insert(pos, v);
        end else begin
          run_overflow = 1'b1;
        end
        if (in_tlast) begin
          foreach (run_held[k]) begin
            want.value    = run_held[k];
            want.last     = (k == run_held.size() - 1);
            want.overflow = run_overflow;
            sorted_expected.insert(sorted_expected.size(), want);
          end
          run_held.delete();
          run_overflow = 1'b0;
        end
      end
    end
    failures <= fail_count;
    pending  <= sorted_expected.size();
  end

endmodule

// ----- tb/merge_insertion_sorter_tb.sv -----
// Testbench top for merge_insertion_sorter: clock, reset, run stimulus with
// sender gaps and receiver stalls, and the verdict.
// Depends on merge_insertion_sorter and merge_insertion_sorter_checker.
module merge_insertion_sorter_tb;

  localparam int MAX_ITEMS    = 64;
  localparam int VALUE_WIDTH  = 32;
  localparam int DATA_W       = ((VALUE_WIDTH+7)/8)*8;
  localparam int HOLD_LEN     = 300;
  localparam int RANDOM_ITEMS = 100;
  localparam int LIMIT_CYCLES = 200000;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata;
  logic              in_tlast;
  logic              out_tvalid;
  logic              out_tready;
  logic [DATA_W-1:0] out_tdata;
  logic              out_tlast;
  logic              out_tuser;

  int unsigned failures;
  int unsigned pending;
  int unsigned idle_pct;
  int unsigned stall_pct;
  logic        hold_req;
  logic        hold_done;

  merge_insertion_sorter #(
    .MAX_ITEMS   (MAX_ITEMS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  merge_insertion_sorter_checker #(
    .MAX_ITEMS   (MAX_ITEMS),
    .VALUE_WIDTH (VALUE_WIDTH),
    .DATA_W      (DATA_W)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .failures   (failures),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #(2 * LIMIT_CYCLES);
    $display("status: fail");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_tready = 1'b0;
    hold_done  = 1'b0;
    forever begin
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
        @(posedge clk);
      end
    end
  end

  task automatic send_item(input logic [DATA_W-1:0] v, input logic is_last);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    in_tlast  <= is_last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_random_run(input int unsigned len);
    int unsigned       flavour;
    logic [DATA_W-1:0] v;
    flavour = $urandom_range(0, 3);
    for (int unsigned i = 0; i < len; i++) begin
      case (flavour)
        0, 1: v = $urandom;
        2: v = DATA_W'($urandom_range(0, 14) - 7);
        default: begin
          case ($urandom_range(0, 3))
            0: v = {1'b1, {(DATA_W-1){1'b0}}};
            1: v = {1'b0, {(DATA_W-1){1'b1}}};
            2: v = '0;
            default: v = $urandom;
          endcase
        end
      endcase
      send_item(v, i == len - 1);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned       sent;
    int unsigned       run_idx;
    int unsigned       len;
    logic [DATA_W-1:0] extremes[8];
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = 1'b0;
    extremes  = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff,
                  32'h1, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single-value runs at both ends of the range, a run of extremes, a run of equal values
    send_item(32'h8000_0000, 1'b1);
    send_item(32'h7fff_ffff, 1'b1);
    foreach (extremes[i])
      send_item(extremes[i], i == 7);
    for (int i = 0; i < 4; i++)
      send_item(32'd5, i == 3);
    wait_drained();

    // long receiver hold-off: send two runs while the receiver holds, stalling the input
    hold_req <= 1'b1;
    send_random_run(12);
    send_random_run(6);
    while (!hold_done) @(posedge clk);
    wait_drained();

    sent    = 0;
    run_idx = 0;
    while (sent < RANDOM_ITEMS) begin
      case (run_idx % 4)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 49; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 49; end
        default: begin idle_pct = 34; stall_pct <= 34; end
      endcase
      if (run_idx == 2)
        len = MAX_ITEMS + $urandom_range(1, 4);
      else
        len = $urandom_range(1, 12);
      send_random_run(len);
      sent += len;
      run_idx++;
      if (run_idx == 6)
        wait_drained();
    end

    wait_drained();
    repeat (2 * MAX_ITEMS) @(posedge clk);
    if (failures == 0 && pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/mis_pkg.sv
hdl/mis_cell.sv
hdl/merge_insertion_sorter.sv
tb/merge_insertion_sorter_checker.sv
tb/merge_insertion_sorter_tb.sv
